@@ design/cprs_pkg.sv @@
// ----------------------------------------------------------------------------
// cprs_pkg: shared types and constants for the code point range set
// Command codes, status codes, payload structs and sizing helpers.
// ----------------------------------------------------------------------------
package cprs_pkg;

    localparam int CP_W            = 21;
    localparam int CMD_W           = 2;
    localparam int STATUS_W        = 2;
    localparam int COUNT_OUT_W     = 7;
    localparam int MAX_RANGES_DEF  = 64;

    localparam logic [CP_W-1:0] CP_LIMIT = 21'h10FFFF;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEAL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CP_W-1:0]  range_low;
        logic [CP_W-1:0]  range_high;
        logic [CP_W-1:0]  query_point;
    } cprs_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   is_member;
        logic [COUNT_OUT_W-1:0] stored_count;
    } cprs_out_t;

    // one range as held by a cell
    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
    } cprs_range_t;

endpackage

@@ design/cprs_cell.sv @@
// ----------------------------------------------------------------------------
// cprs_cell: one slot of the range chain
// Holds one range, tests a broadcast point against it, and takes part in an
// odd-even transposition step with its left or right neighbor during a sort.
// ----------------------------------------------------------------------------
module cprs_cell
    import cprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,      // take load_val
    input  cprs_range_t load_val,
    input  logic        swap_en,   // this cell is the left of an active pair
    input  logic        swap_right,// this cell is the right of an active pair
    input  cprs_range_t left_in,   // left neighbor content
    input  cprs_range_t right_in,  // right neighbor content
    input  logic [CP_W-1:0] point,
    output cprs_range_t cur,
    output logic        hit
);

    cprs_range_t slot_reg, slot_next;
    logic        right_less, left_greater;

    // a valid entry sorts before an invalid one
    function automatic logic less_than(cprs_range_t a, cprs_range_t b);
        if (!b.valid)
            return a.valid;
        if (!a.valid)
            return 1'b0;
        return (a.lo < b.lo) || (a.lo == b.lo && a.hi < b.hi);
    endfunction

    assign right_less   = less_than(right_in, slot_reg);
    assign left_greater = less_than(slot_reg, left_in);

    always_comb
    begin
        slot_next = slot_reg;
        if (load)
            slot_next = load_val;
        else if (swap_en && right_less)
            slot_next = right_in;
        else if (swap_right && left_greater)
            slot_next = left_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    assign cur = slot_reg;
    assign hit = slot_reg.valid && point >= slot_reg.lo && point <= slot_reg.hi;

endmodule

@@ design/code_point_range_set.sv @@
// ----------------------------------------------------------------------------
// code_point_range_set: table of Unicode code point ranges
// Add, seal (sort and merge) and membership query over a chain of cells.
// ----------------------------------------------------------------------------
// channel | direction | signals
// command | in        | start, busy, in_word (cprs_in_t)
// result  | out       | done, out_word (cprs_out_t)
//
// Add, query, unused code and seal of an empty table: the word passes through the
// execute and response states and done is registered after the response state;
// busy holds through the done cycle, so the next word is taken after the result.
// Seal: odd-even sort passes over all cells, then a merge pass over the stored
// ranges in order that folds overlapping or adjacent ones, then the response.
// Reset clears all cells and the count at once; no clearing pass.
// The receiver cannot stall: done is high for one cycle per command word.
// ----------------------------------------------------------------------------
module code_point_range_set
    import cprs_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  cprs_in_t  in_word,
    output logic      done,
    output cprs_out_t out_word
);

    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int IDX_W = $clog2(MAX_RANGES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SORT  = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]       state_reg, state_next;
    cprs_in_t         cmd_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] step_reg, step_next;   // sort pass or merge read index
    logic [IDX_W-1:0] wr_reg, wr_next;        // merge write index
    logic [STATUS_W-1:0] status_reg, status_next;
    logic             member_reg, member_next;
    logic             done_reg;
    cprs_out_t        out_reg;

    cprs_range_t cur   [MAX_RANGES];
    cprs_range_t lval  [MAX_RANGES];
    logic        load  [MAX_RANGES];
    logic        sw_l  [MAX_RANGES];
    logic        sw_r  [MAX_RANGES];
    logic [MAX_RANGES-1:0] hits;
    cprs_range_t rd_ent, wr_ent;
    logic        is_sort;
    logic        add_ok;
    logic        accept;
    logic [CP_W-1:0] hi_clamped;

    assign accept  = start && !busy;
    assign is_sort = (state_reg == S_SORT);
    assign rd_ent  = cur[step_reg[IDX_W-1:0]];
    assign wr_ent  = cur[wr_reg];
    assign hi_clamped = (cmd_reg.range_high > CP_LIMIT) ? CP_LIMIT : cmd_reg.range_high;
    assign add_ok = (state_reg == S_EXEC) && cmd_reg.cmd == CMD_ADD
                    && !(cmd_reg.range_low > cmd_reg.range_high)
                    && !(cmd_reg.range_low > CP_LIMIT)
                    && count_reg < CNT_W'(MAX_RANGES);

    genvar g;
    generate
        for (g = 0; g < MAX_RANGES; g++)
        begin : g_cell
            localparam logic PAR = ((g % 2) == 1);
            always_comb
            begin
                load[g] = 1'b0;
                lval[g] = cur[g];
                if (add_ok && count_reg[IDX_W-1:0] == IDX_W'(g))
                begin
                    load[g] = 1'b1;
                    lval[g] = '{valid: 1'b1, lo: cmd_reg.range_low, hi: hi_clamped};
                end
                else if (state_reg == S_MERGE)
                begin
                    if (step_reg >= count_reg)
                    begin
                        // drop everything past the merged list
                        load[g] = (IDX_W'(g) > wr_reg);
                        lval[g].valid = 1'b0;
                    end
                    else if ({1'b0, rd_ent.lo} <= {1'b0, wr_ent.hi} + 22'd1)
                    begin
                        load[g] = (IDX_W'(g) == wr_reg) && rd_ent.hi > wr_ent.hi;
                        lval[g].hi = rd_ent.hi;
                    end
                    else
                    begin
                        load[g] = (IDX_W'(g) == wr_reg + IDX_W'(1));
                        lval[g] = rd_ent;
                    end
                end
                sw_l[g] = is_sort && (g < MAX_RANGES - 1) && (PAR == step_reg[0]);
                sw_r[g] = is_sort && (g > 0) && (PAR != step_reg[0]);
            end
            cprs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (load[g]),
                .load_val  (lval[g]),
                .swap_en   (sw_l[g]),
                .swap_right(sw_r[g]),
                .left_in   (cur[(g == 0) ? 0 : g - 1]),
                .right_in  (cur[(g == MAX_RANGES - 1) ? g : g + 1]),
                .point     (cmd_reg.query_point),
                .cur       (cur[g]),
                .hit       (hits[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        wr_next     = wr_reg;
        status_next = status_reg;
        member_next = member_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                status_next = ST_DONE;
                member_next = 1'b0;
                state_next  = S_RESP;
                case (cmd_reg.cmd)
                    CMD_ADD:
                    begin
                        if (cmd_reg.range_low > cmd_reg.range_high
                            || cmd_reg.range_low > CP_LIMIT)
                            status_next = ST_EMPTY;
                        else if (!add_ok)
                            status_next = ST_FULL;
                        else
                            count_next = count_reg + CNT_W'(1);
                    end
                    CMD_SEAL:
                    begin
                        if (count_reg != '0)
                        begin
                            step_next  = '0;
                            state_next = S_SORT;
                        end
                    end
                    CMD_QUERY:
                        member_next = |hits;
                    default: ;
                endcase
            end
            S_SORT:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(MAX_RANGES))
                begin
                    step_next  = CNT_W'(1);
                    wr_next    = '0;
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                if (step_reg >= count_reg)
                begin
                    count_next = CNT_W'(wr_reg) + CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    if (!({1'b0, rd_ent.lo} <= {1'b0, wr_ent.hi} + 22'd1))
                        wr_next = wr_reg + IDX_W'(1);
                    step_next = step_reg + CNT_W'(1);
                end
            end
            S_RESP:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            wr_reg     <= '0;
            status_reg <= ST_DONE;
            member_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            wr_reg     <= wr_next;
            status_reg <= status_next;
            member_reg <= member_next;
            done_reg   <= (state_reg == S_RESP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= in_word;
        if (state_reg == S_RESP)
        begin
            out_reg.status       <= status_reg;
            out_reg.is_member    <= member_reg;
            out_reg.stored_count <= COUNT_OUT_W'(count_reg);
        end
    end

    assign busy     = (state_reg != S_IDLE) || done_reg;
    assign done     = done_reg;
    assign out_word = out_reg;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RANGES))
        else $error("range count above capacity");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start && !busy) |=> state_reg == S_EXEC)
        else $error("accepted word not executed");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for code_point_range_set
// Sends add, seal, query and unused-code command words with random start gaps, tracks the
// range table in a local predictor and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_top;
    import cprs_pkg::*;

    localparam int  NUM_RANDOM  = 1160;
    localparam int  QUIET_TAIL  = 200;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  N_DIRECTED  = 20;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [CP_W-1:0]  CP_MAX     = 21'h1FFFFF;

    typedef struct {
        cprs_in_t  word;
        bit        typed;
        cprs_out_t result;
    } directed_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    cprs_in_t  in_word;
    logic      done;
    cprs_out_t out_word;

    // predictor copy of the range table
    logic [CP_W-1:0] set_lo [MAX_RANGES_DEF];
    logic [CP_W-1:0] set_hi [MAX_RANGES_DEF];
    int              set_count;

    cprs_out_t       pending_results [$];
    int              mismatches = 0;
    int              cycles = 0;
    directed_row_t   directed [N_DIRECTED];

    code_point_range_set u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .in_word  (in_word),
        .done     (done),
        .out_word (out_word)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic void sort_and_merge();
        logic [CP_W-1:0] klo, khi;
        int j, w;
        if (set_count == 0)
            return;
        for (int i = 1; i < set_count; i++)
        begin
            klo = set_lo[i];
            khi = set_hi[i];
            j = i;
            while (j > 0 && (klo < set_lo[j-1] || (klo == set_lo[j-1] && khi < set_hi[j-1])))
            begin
                set_lo[j] = set_lo[j-1];
                set_hi[j] = set_hi[j-1];
                j--;
            end
            set_lo[j] = klo;
            set_hi[j] = khi;
        end
        w = 0;
        for (int i = 1; i < set_count; i++)
        begin
            if ({1'b0, set_lo[i]} <= {1'b0, set_hi[w]} + 22'd1)
            begin
                if (set_hi[i] > set_hi[w])
                    set_hi[w] = set_hi[i];
            end
            else
            begin
                w++;
                set_lo[w] = set_lo[i];
                set_hi[w] = set_hi[i];
            end
        end
        set_count = w + 1;
    endfunction

    function automatic cprs_out_t apply_command(cprs_in_t w);
        cprs_out_t r;
        r.status    = ST_DONE;
        r.is_member = 1'b0;
        case (w.cmd)
            CMD_ADD:
            begin
                if (w.range_low > w.range_high || w.range_low > CP_LIMIT)
                    r.status = ST_EMPTY;
                else if (set_count >= MAX_RANGES_DEF)
                    r.status = ST_FULL;
                else
                begin
                    set_lo[set_count] = w.range_low;
                    set_hi[set_count] = (w.range_high > CP_LIMIT) ? CP_LIMIT : w.range_high;
                    set_count++;
                end
            end
            CMD_SEAL:
                sort_and_merge();
            CMD_QUERY:
            begin
                for (int i = 0; i < set_count; i++)
                    if (w.query_point >= set_lo[i] && w.query_point <= set_hi[i])
                        r.is_member = 1'b1;
            end
            default: ;
        endcase
        r.stored_count = set_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic cprs_in_t make_word(logic [CMD_W-1:0] c, logic [CP_W-1:0] lo,
                                           logic [CP_W-1:0] hi, logic [CP_W-1:0] qp);
        cprs_in_t w;
        w.cmd         = c;
        w.range_low   = lo;
        w.range_high  = hi;
        w.query_point = qp;
        return w;
    endfunction

    function automatic cprs_out_t make_result(logic [STATUS_W-1:0] s, logic m, int n);
        cprs_out_t r;
        r.status       = s;
        r.is_member    = m;
        r.stored_count = n[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [CP_W-1:0] rand_cp();
        return CP_W'($urandom_range(0, CP_MAX));
    endfunction

    // hold start until the word is taken, then predict its result
    task automatic send_command(cprs_in_t w, bit typed, cprs_out_t typed_result, int gap);
        cprs_out_t predicted;
        start   <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_command(w);
        pending_results = {pending_results, (typed ? typed_result : predicted)};
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [CP_W-1:0] pick_point();
        int k;
        k = $urandom_range(0, 9);
        if (set_count > 0 && k < 7)
        begin
            k = $urandom_range(0, set_count - 1);
            case ($urandom_range(0, 3))
                0: return set_lo[k] - 21'd1;
                1: return set_lo[k];
                2: return set_hi[k];
                default: return set_hi[k] + 21'd1;
            endcase
        end
        return rand_cp();
    endfunction

    function automatic cprs_in_t random_command();
        logic [CP_W-1:0] lo, hi;
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
        begin
            case ($urandom_range(0, 9))
                0: lo = rand_cp();
                1: lo = CP_LIMIT - CP_W'($urandom_range(0, 3));
                default: lo = CP_W'($urandom_range(0, CP_LIMIT));
            endcase
            case ($urandom_range(0, 9))
                0: hi = rand_cp();
                1: hi = lo - CP_W'($urandom_range(1, 4));
                2: hi = lo + CP_W'($urandom_range(0, 2097151 - lo));
                default: hi = lo + CP_W'($urandom_range(0, 3000));
            endcase
            if (hi < lo && $urandom_range(0, 3) != 0)
                hi = lo;
            return make_word(CMD_ADD, lo, hi, rand_cp());
        end
        if (k < 47)
            return make_word(CMD_ADD, 21'd0, CP_MAX, rand_cp());
        if (k < 53)
            return make_word(CMD_SEAL, rand_cp(), rand_cp(), rand_cp());
        if (k < 55)
            return make_word(CMD_UNUSED, rand_cp(), rand_cp(), rand_cp());
        return make_word(CMD_QUERY, rand_cp(), rand_cp(), pick_point());
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        cprs_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", out_word);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_word.status !== want.status || out_word.is_member !== want.is_member
                    || out_word.stored_count !== want.stored_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d mem=%0d cnt=%0d, got st=%0d mem=%0d cnt=%0d",
                                 want.status, want.is_member, want.stored_count,
                                 out_word.status, out_word.is_member, out_word.stored_count);
                end
            end
        end
    end

    initial
    begin
        cprs_in_t  w;
        int        gap;
        rst_n      = 1'b0;
        start      = 1'b0;
        in_word    = '0;
        set_count  = 0;

        directed[0]  = '{make_word(CMD_QUERY, '0, '0, '0), 1'b1,
                         make_result(ST_DONE, 1'b0, 0)};
        directed[1]  = '{make_word(CMD_SEAL, '0, '0, '0), 1'b1,
                         make_result(ST_DONE, 1'b0, 0)};
        directed[2]  = '{make_word(CMD_ADD, 21'd5, 21'd4, '0), 1'b1,
                         make_result(ST_EMPTY, 1'b0, 0)};
        directed[3]  = '{make_word(CMD_ADD, 21'h110000, CP_MAX, '0), 1'b1,
                         make_result(ST_EMPTY, 1'b0, 0)};
        directed[4]  = '{make_word(CMD_ADD, CP_MAX, CP_MAX, CP_MAX), 1'b1,
                         make_result(ST_EMPTY, 1'b0, 0)};
        directed[5]  = '{make_word(CMD_ADD, CP_LIMIT, CP_MAX, '0), 1'b1,
                         make_result(ST_DONE, 1'b0, 1)};
        directed[6]  = '{make_word(CMD_QUERY, CP_MAX, CP_MAX, CP_LIMIT), 1'b1,
                         make_result(ST_DONE, 1'b1, 1)};
        directed[7]  = '{make_word(CMD_QUERY, '0, '0, 21'h110000), 1'b1,
                         make_result(ST_DONE, 1'b0, 1)};
        directed[8]  = '{make_word(CMD_QUERY, '0, '0, CP_MAX), 1'b1,
                         make_result(ST_DONE, 1'b0, 1)};
        directed[9]  = '{make_word(CMD_UNUSED, CP_MAX, CP_MAX, CP_LIMIT), 1'b1,
                         make_result(ST_DONE, 1'b0, 1)};
        directed[10] = '{make_word(CMD_ADD, '0, '0, CP_MAX), 1'b1,
                         make_result(ST_DONE, 1'b0, 2)};
        directed[11] = '{make_word(CMD_ADD, 21'd10, 21'd20, '0), 1'b0, '0};
        directed[12] = '{make_word(CMD_ADD, 21'd21, 21'd30, '0), 1'b0, '0};
        directed[13] = '{make_word(CMD_ADD, 21'd2, 21'd8, '0), 1'b0, '0};
        directed[14] = '{make_word(CMD_ADD, 21'd15, 21'd40, '0), 1'b0, '0};
        directed[15] = '{make_word(CMD_QUERY, '0, '0, 21'd9), 1'b0, '0};
        directed[16] = '{make_word(CMD_SEAL, CP_MAX, CP_MAX, CP_MAX), 1'b0, '0};
        directed[17] = '{make_word(CMD_QUERY, '0, '0, 21'd41), 1'b0, '0};
        directed[18] = '{make_word(CMD_QUERY, '0, '0, 21'd1), 1'b0, '0};
        directed[19] = '{make_word(CMD_ADD, '0, CP_MAX, '0), 1'b0, '0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_command(directed[i].word, directed[i].typed, directed[i].result,
                         ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);

        // fill the table with disjoint single points, then overflow it
        for (int i = 0; i < MAX_RANGES_DEF + 2; i++)
            send_command(make_word(CMD_ADD, CP_W'(4 * i + 100), CP_W'(4 * i + 100), '0),
                         1'b0, '0, 0);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            w = random_command();
            gap = 0;
            if (i < NUM_RANDOM - QUIET_TAIL && ($urandom_range(0, 3) == 0))
                gap = $urandom_range(1, 4);
            send_command(w, 1'b0, '0, gap);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
